[hw/rtl/qtm_pkg.sv]
// Package with payload types and fixed widths of the quaternion transform block.
package qtm_pkg;

    // Width of the divisor (squared quaternion length, up to 2^32).
    localparam int DEN_W = 33;
    // Width of the numerator |P| * |s| * 512.
    localparam int NUM_W = 58;
    // Quotient bits of floor(2 * |P| * |s| * 256 / den); the true value stays below 2^25.
    localparam int QB = 25;
    // Rotation entries per item.
    localparam int NENT = 9;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m03;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
    } out_t;

endpackage

[hw/rtl/quaternion_trs_to_matrix.sv]
// Top level: quaternion, scale and position to a 3x4 affine matrix.
//
// Each item carries a Q16.16 position, a Q2.13 quaternion of any length and a
// Q8.8 per-row scale; the result item holds the upper twelve entries of the
// affine matrix in Q16.16, rows scaled and the position as the last column.
// Each rotation entry is computed exactly as round(P * s * 256 / L), where L
// is the squared quaternion length, ties away from zero; a zero quaternion
// gives the identity rotation. The block accepts one item every cycle while
// the output is not stalled and has one input register, one stage of 16x16
// products, one stage forming the numerators and the divisor, one stage of
// 33x16 scale products, 25 stages of the bit-per-stage divider and an output
// register. The whole pipeline advances together; when the output item is
// not taken, every stage holds, so nothing is lost or repeated.
module quaternion_trs_to_matrix
    import qtm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int DEPTH = QB + 5;
    localparam int SIDE_W = 96 + NENT;

    logic             adv;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv      = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: input register.
    in_t s1_reg;

    // Stage 2: squares and cross products of the quaternion.
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic [95:0]        pos2_reg;
    logic [47:0]        scl2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= in_data;
            xx_reg   <= s1_reg.quat_x * s1_reg.quat_x;
            yy_reg   <= s1_reg.quat_y * s1_reg.quat_y;
            zz_reg   <= s1_reg.quat_z * s1_reg.quat_z;
            ww_reg   <= s1_reg.quat_w * s1_reg.quat_w;
            xy_reg   <= s1_reg.quat_x * s1_reg.quat_y;
            xz_reg   <= s1_reg.quat_x * s1_reg.quat_z;
            yz_reg   <= s1_reg.quat_y * s1_reg.quat_z;
            wx_reg   <= s1_reg.quat_w * s1_reg.quat_x;
            wy_reg   <= s1_reg.quat_w * s1_reg.quat_y;
            wz_reg   <= s1_reg.quat_w * s1_reg.quat_z;
            pos2_reg <= {s1_reg.pos_x, s1_reg.pos_y, s1_reg.pos_z};
            scl2_reg <= {s1_reg.scale_x, s1_reg.scale_y, s1_reg.scale_z};
        end
    end

    // Stage 3: numerators P, the divisor, magnitudes and result signs.
    logic signed [34:0] len_s;
    logic signed [34:0] den_s;
    logic signed [34:0] p_s [NENT];
    logic signed [15:0] scl_s [3];
    logic [15:0]        sabs_next [3];
    logic [DEN_W-1:0]   pabs_next [NENT];
    logic [NENT-1:0]    neg_next;

    always_comb
    begin
        len_s = 35'(xx_reg) + 35'(yy_reg) + 35'(zz_reg) + 35'(ww_reg);
        // A zero quaternion divides by one, which leaves the identity.
        den_s = (len_s == '0) ? 35'sd1 : len_s;
        p_s[0] = den_s - ((35'(yy_reg) + 35'(zz_reg)) <<< 1);
        p_s[1] = (35'(xy_reg) - 35'(wz_reg)) <<< 1;
        p_s[2] = (35'(xz_reg) + 35'(wy_reg)) <<< 1;
        p_s[3] = (35'(xy_reg) + 35'(wz_reg)) <<< 1;
        p_s[4] = den_s - ((35'(xx_reg) + 35'(zz_reg)) <<< 1);
        p_s[5] = (35'(yz_reg) - 35'(wx_reg)) <<< 1;
        p_s[6] = (35'(xz_reg) - 35'(wy_reg)) <<< 1;
        p_s[7] = (35'(yz_reg) + 35'(wx_reg)) <<< 1;
        p_s[8] = den_s - ((35'(xx_reg) + 35'(yy_reg)) <<< 1);
        scl_s[0] = scl2_reg[47:32];
        scl_s[1] = scl2_reg[31:16];
        scl_s[2] = scl2_reg[15:0];
        for (int r = 0; r < 3; r++)
        begin
            sabs_next[r] = scl_s[r][15] ? 16'(-scl_s[r]) : 16'(scl_s[r]);
        end
        for (int j = 0; j < NENT; j++)
        begin
            pabs_next[j] = p_s[j][34] ? DEN_W'(-p_s[j]) : DEN_W'(p_s[j]);
            neg_next[j]  = p_s[j][34] ^ scl_s[j / 3][15];
        end
    end

    logic [DEN_W-1:0] pabs_reg [NENT];
    logic [15:0]      sabs_reg [3];
    logic [DEN_W-1:0] den3_reg;
    logic [SIDE_W-1:0] side3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pabs_reg  <= pabs_next;
            sabs_reg  <= sabs_next;
            den3_reg  <= den_s[DEN_W-1:0];
            side3_reg <= {pos2_reg, neg_next};
        end
    end

    // Stage 4: numerators scaled by |s| * 512 for the divider.
    logic [NUM_W-1:0]  num_reg [NENT];
    logic [DEN_W-1:0]  den4_reg;
    logic [SIDE_W-1:0] side4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < NENT; j++)
            begin
                num_reg[j] <= {49'(pabs_reg[j]) * 49'(sabs_reg[j / 3]), 9'b0};
            end
            den4_reg  <= den3_reg;
            side4_reg <= side3_reg;
        end
    end

    // Divider lanes and the matching delay line for position and signs.
    logic [QB-1:0] quo [NENT];

    for (genvar j = 0; j < NENT; j++) begin : g_lane
        qtm_div u_div (
            .clk (clk),
            .en  (adv),
            .num (num_reg[j]),
            .den (den4_reg),
            .quo (quo[j])
        );
    end

    logic [SIDE_W-1:0] side_reg [QB];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side4_reg;
            for (int k = 1; k < QB; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Output stage: apply the sign. Magnitudes stay below 2^25, so the
    // signed 32-bit range is never exceeded and no saturation is needed.
    logic signed [31:0] ent_next [NENT];
    logic [NENT-1:0]    neg_d;
    logic [95:0]        pos_d;
    out_t               out_next;
    out_t               out_reg;

    always_comb
    begin
        neg_d = side_reg[QB-1][NENT-1:0];
        pos_d = side_reg[QB-1][SIDE_W-1:NENT];
        for (int j = 0; j < NENT; j++)
        begin
            ent_next[j] = neg_d[j] ? -32'(quo[j]) : 32'(quo[j]);
        end
        out_next.m00 = ent_next[0];
        out_next.m01 = ent_next[1];
        out_next.m02 = ent_next[2];
        out_next.m03 = pos_d[95:64];
        out_next.m10 = ent_next[3];
        out_next.m11 = ent_next[4];
        out_next.m12 = ent_next[5];
        out_next.m13 = pos_d[63:32];
        out_next.m20 = ent_next[6];
        out_next.m21 = ent_next[7];
        out_next.m22 = ent_next[8];
        out_next.m23 = pos_d[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = out_reg;

endmodule

[hw/rtl/qtm_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with rounding to nearest.
module qtm_div
    import qtm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QB-1:0]    quo
);

    logic [DEN_W-1:0] rem_reg [QB];
    logic [DEN_W-1:0] den_reg [QB];
    logic [QB-1:0]    low_reg [QB];
    logic [QB-1:0]    q_reg   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DEN_W-1:0] rem_prev;
        logic [DEN_W-1:0] den_prev;
        logic [QB-1:0]    low_prev;
        logic [QB-1:0]    q_prev;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (k == 0) begin : g_first
            // The quotient fits in QB bits, so the top bits start below the divisor.
            assign rem_prev = num[NUM_W-1:QB];
            assign den_prev = den;
            assign low_prev = num[QB-1:0];
            assign q_prev   = '0;
        end else begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign low_prev = low_reg[k-1];
            assign q_prev   = q_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_prev, low_prev[QB-1]};
            ge       = (trial >= {1'b0, den_prev});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_prev;
                low_reg[k] <= {low_prev[QB-2:0], 1'b0};
                q_reg[k]   <= {q_prev[QB-2:0], ge};
            end
        end
    end

    // floor((2n + d) / 2d) equals (floor(2n / d) + 1) / 2.
    logic [QB:0] q_inc;
    assign q_inc = {1'b0, q_reg[QB-1]} + (QB+1)'(1);
    assign quo   = q_inc[QB:1];

endmodule

[hw/rtl/qtm_checker.sv]
// Port-level checker of the quaternion transform block and its bind.
module qtm_checker
    import qtm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // A waiting result item holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // With no result waiting the block must take input.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused while output is empty");

    // A stalled output freezes the pipeline, so no input may enter.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output is stalled");

endmodule

bind quaternion_trs_to_matrix qtm_checker u_qtm_checker (.*);

[sim/quaternion_trs_to_matrix_test.sv]
// Testbench for the quaternion, scale and position to affine matrix block.
`timescale 1ns / 100ps

module quaternion_trs_to_matrix_test;
    import qtm_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    quaternion_trs_to_matrix u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Pipeline depth of the block, used for the final drain.
    localparam int PIPE_DEPTH = 30;
    localparam int CYCLE_LIMIT = 200000;

    in_t  pending_items[$];
    out_t expected_matrices[$];
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   hold_off_cycles;
    bit   hold_off_request;
    int   error_count;
    longint cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // One rotation entry: round(p * s * 256 / den) with ties away from zero,
    // clamped to the signed 32-bit range. The numerator fits in 64 bits since
    // |p| <= 2^32, |s| <= 2^15 and the factor 256 adds 8 bits.
    function automatic logic signed [31:0] scaled_entry(longint p, longint s, longint den);
        bit negative;
        longint unsigned mag_p;
        longint unsigned mag_s;
        longint unsigned num;
        longint unsigned quo;
        longint res;
        negative = (p < 0) != (s < 0);
        mag_p = (p < 0) ? -p : p;
        mag_s = (s < 0) ? -s : s;
        num = mag_p * mag_s * 256;
        quo = (2 * num + den) / (2 * den);
        res = negative ? -longint'(quo) : longint'(quo);
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // Affine matrix of one transform. Dividing the raw products by the squared
    // length is the same as normalising the quaternion first.
    function automatic out_t affine_matrix(in_t t);
        longint qx, qy, qz, qw, sx, sy, sz;
        longint len_sq, den;
        out_t m;
        qx = t.quat_x;
        qy = t.quat_y;
        qz = t.quat_z;
        qw = t.quat_w;
        sx = t.scale_x;
        sy = t.scale_y;
        sz = t.scale_z;
        len_sq = qx * qx + qy * qy + qz * qz + qw * qw;
        // A zero quaternion keeps its zero products, leaving the identity.
        den = (len_sq > 0) ? len_sq : 1;
        m.m00 = scaled_entry(den - 2 * (qy * qy + qz * qz), sx, den);
        m.m01 = scaled_entry(2 * (qx * qy - qw * qz), sx, den);
        m.m02 = scaled_entry(2 * (qx * qz + qw * qy), sx, den);
        m.m03 = t.pos_x;
        m.m10 = scaled_entry(2 * (qx * qy + qw * qz), sy, den);
        m.m11 = scaled_entry(den - 2 * (qx * qx + qz * qz), sy, den);
        m.m12 = scaled_entry(2 * (qy * qz - qw * qx), sy, den);
        m.m13 = t.pos_y;
        m.m20 = scaled_entry(2 * (qx * qz - qw * qy), sz, den);
        m.m21 = scaled_entry(2 * (qy * qz + qw * qx), sz, den);
        m.m22 = scaled_entry(den - 2 * (qx * qx + qy * qy), sz, den);
        m.m23 = t.pos_z;
        return m;
    endfunction

    function automatic in_t make_transform(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                           logic [15:0] w, logic [15:0] s0,
                                           logic [15:0] s1, logic [15:0] s2);
        in_t t;
        t.pos_x = $urandom;
        t.pos_y = $urandom;
        t.pos_z = $urandom;
        t.quat_x = x;
        t.quat_y = y;
        t.quat_z = z;
        t.quat_w = w;
        t.scale_x = s0;
        t.scale_y = s1;
        t.scale_z = s2;
        return t;
    endfunction

    // Random 16-bit field: mostly full-range, sometimes an extreme or small.
    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Appends one item to the tail of the pending list.
    task automatic queue_item(in_t t);
        pending_items.insert(pending_items.size(), t);
    endtask

    // Compares one result field and reports a mismatch.
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s expected %0d got %0d", name, $signed(exp_v), $signed(act_v));
            error_count++;
        end
    endtask

    // Driver: offers the oldest pending item; valid stays up until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_matrices.insert(expected_matrices.size(), affine_matrix(in_data));
                void'(pending_items.pop_front());
            end
            if (in_valid && !in_ready)
            begin
                // Item still on offer; leave it alone.
            end
            else if (pending_items.size() > 0 &&
                     $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, including a long hold-off counted here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= 0;
        end
        else if (hold_off_request && hold_off_cycles == 0)
        begin
            hold_off_cycles <= 200;
            out_ready <= 1'b0;
        end
        else if (hold_off_cycles > 1)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (hold_off_cycles == 1)
                hold_off_cycles <= -1;
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Monitor: checks every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_matrices.size() == 0)
            begin
                $error("Result with no item pending: %p", out_data);
                error_count++;
            end
            else
            begin
                out_t exp_m;
                exp_m = expected_matrices.pop_front();
                check_field("m00", exp_m.m00, out_data.m00);
                check_field("m01", exp_m.m01, out_data.m01);
                check_field("m02", exp_m.m02, out_data.m02);
                check_field("m03", exp_m.m03, out_data.m03);
                check_field("m10", exp_m.m10, out_data.m10);
                check_field("m11", exp_m.m11, out_data.m11);
                check_field("m12", exp_m.m12, out_data.m12);
                check_field("m13", exp_m.m13, out_data.m13);
                check_field("m20", exp_m.m20, out_data.m20);
                check_field("m21", exp_m.m21, out_data.m21);
                check_field("m22", exp_m.m22, out_data.m22);
                check_field("m23", exp_m.m23, out_data.m23);
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        in_t t;
        error_count = 0;
        cycle_count = 0;
        hold_off_request = 1'b0;
        sender_idle_pct = 35;
        receiver_idle_pct = 45;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items: identity, zero quaternion, axis rotations, extreme
        // components and scales, positional extremes and non-unit lengths.
        queue_item(make_transform(16'h0000, 16'h0000, 16'h0000, 16'h2000,
                                  16'h0100, 16'h0100, 16'h0100));
        queue_item(make_transform(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h7fff, 16'h8000, 16'h0001));
        queue_item(make_transform(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  16'hffff, 16'h0000, 16'h7fff));
        queue_item(make_transform(16'h2000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0100, 16'hff00, 16'h0200));
        queue_item(make_transform(16'h0000, 16'h2000, 16'h0000, 16'h0000,
                                  16'h0100, 16'h0100, 16'h0100));
        queue_item(make_transform(16'h0000, 16'h0000, 16'h2000, 16'h0000,
                                  16'h0100, 16'h0100, 16'h0100));
        queue_item(make_transform(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h7fff, 16'h7fff, 16'h7fff));
        queue_item(make_transform(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                  16'h8000, 16'h8000, 16'h8000));
        queue_item(make_transform(16'h8000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h8000, 16'h7fff, 16'hffff));
        queue_item(make_transform(16'h0001, 16'h0000, 16'h0000, 16'h0000,
                                  16'h7fff, 16'h7fff, 16'h7fff));
        queue_item(make_transform(16'h0001, 16'hffff, 16'h0001, 16'hffff,
                                  16'h0003, 16'hfffd, 16'h0005));
        queue_item(make_transform(16'h1000, 16'h1000, 16'h1000, 16'h1000,
                                  16'h0080, 16'hff80, 16'h0001));
        queue_item(make_transform(16'h0000, 16'h7fff, 16'h0000, 16'h8000,
                                  16'h0000, 16'h0000, 16'h0000));
        t = make_transform(16'h0000, 16'h0000, 16'h0000, 16'h2000,
                           16'h0100, 16'h0100, 16'h0100);
        t.pos_x = 32'h7fffffff;
        t.pos_y = 32'h80000000;
        t.pos_z = 32'hffffffff;
        queue_item(t);
        t.pos_x = 32'h80000000;
        t.pos_y = 32'h7fffffff;
        t.pos_z = 32'h00000000;
        queue_item(t);

        // Random items in three idling phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                sender_idle_pct = 35;
                receiver_idle_pct = 45;
            end
            else if (phase == 1)
            begin
                sender_idle_pct = 45;
                receiver_idle_pct = 35;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            for (int i = 0; i < 245; i++)
                queue_item(make_transform(random_word(), random_word(),
                                          random_word(), random_word(),
                                          random_word(), random_word(),
                                          random_word()));
            // In the last phase the receiver stalls for a long stretch while
            // the sender keeps offering, so the pipeline fills and backs up.
            if (phase == 2)
            begin
                repeat (10) @(posedge clk);
                hold_off_request = 1'b1;
            end
            while (pending_items.size() > 0)
                @(posedge clk);
        end

        // Drain the pipeline, then allow some extra cycles for stray results.
        while (expected_matrices.size() > 0 || in_valid)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
